[hdl/i2c_bit_level_master_top_macros.svh]
// Assertion macros for the I2C bit-level master.
`ifndef I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I2CBM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/i2cbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and codes for the I2C bit-level master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

   localparam int CmdWidth  = 3;
   localparam int ByteWidth = 8;
   localparam int HalfWidth = 16;
   localparam int ToWidth   = 8;
   localparam int AddrWidth = 3;
   localparam int DataWidth = 32;

   localparam logic [CmdWidth-1:0] CMD_NONE     = 3'd0;
   localparam logic [CmdWidth-1:0] CMD_START    = 3'd1;
   localparam logic [CmdWidth-1:0] CMD_STOP     = 3'd2;
   localparam logic [CmdWidth-1:0] CMD_WRITE    = 3'd3;
   localparam logic [CmdWidth-1:0] CMD_READ     = 3'd4;
   localparam logic [CmdWidth-1:0] CMD_SEND_ACK = 3'd5;
   localparam logic [CmdWidth-1:0] CMD_GET_ACK  = 3'd6;

   // register index = paddr[2]
   localparam logic REG_HALF_PERIOD = 1'b0;
   localparam logic REG_ACK_TIMEOUT = 1'b1;

   localparam logic [HalfWidth-1:0] HALF_PERIOD_RESET = 16'd2;
   localparam logic [ToWidth-1:0]   ACK_TIMEOUT_RESET = 8'd250;

   typedef struct packed {
      logic [HalfWidth-1:0] half_period_ticks;
      logic [ToWidth-1:0]   ack_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [CmdWidth-1:0]  cmd;
      logic [ByteWidth-1:0] tx_byte;
      logic                 ack_bit;
      logic                 sda_in;
   } req_type;

   typedef struct packed {
      logic                 scl_out;
      logic                 sda_out;
      logic                 sda_input_mode;
      logic                 busy_res;
      logic                 done_res;
      logic [ByteWidth-1:0] rx_byte;
      logic                 ack_fail;
   } rsp_type;

endpackage

[hdl/i2cbm_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_req_if
// Tick channel into the master: command and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cbm_req_if;
   import i2cbm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CmdWidth-1:0]  cmd;
   logic [ByteWidth-1:0] tx_byte;
   logic                 ack_bit;
   logic                 sda_in;

   modport source (output valid, cmd, tx_byte, ack_bit, sda_in, input ready);
   modport sink   (input valid, cmd, tx_byte, ack_bit, sda_in, output ready);
endinterface

[hdl/i2cbm_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_rsp_if
// Per-tick line and status channel out of the master.
// ----------------------------------------------------------------------------
interface i2cbm_rsp_if;
   import i2cbm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 scl_out;
   logic                 sda_out;
   logic                 sda_input_mode;
   logic                 busy_res;
   logic                 done_res;
   logic [ByteWidth-1:0] rx_byte;
   logic                 ack_fail;

   modport source (output valid, scl_out, sda_out, sda_input_mode, busy_res, done_res,
                   rx_byte, ack_fail, input ready);
   modport sink   (input valid, scl_out, sda_out, sda_input_mode, busy_res, done_res,
                   rx_byte, ack_fail, output ready);
endinterface

[hdl/i2cbm_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_csr
// APB register file: half period and ack timeout.
// ----------------------------------------------------------------------------
module i2cbm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [i2cbm_pkg::AddrWidth-1:0] paddr,
   input  logic [i2cbm_pkg::DataWidth-1:0] pwdata,
   output logic [i2cbm_pkg::DataWidth-1:0] prdata,
   output logic                           pready,
   output i2cbm_pkg::cfg_type             cfg
);
   import i2cbm_pkg::*;

   logic [HalfWidth-1:0] half_ff, half_in;
   logic [ToWidth-1:0]   to_ff, to_in;
   logic                 wr_en;
   logic                 reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      half_in = half_ff;
      to_in   = to_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_HALF_PERIOD: half_in = pwdata[HalfWidth-1:0];
            REG_ACK_TIMEOUT: to_in   = pwdata[ToWidth-1:0];
            default:         half_in = half_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_HALF_PERIOD: prdata = {{(DataWidth-HalfWidth){1'b0}}, half_ff};
         REG_ACK_TIMEOUT: prdata = {{(DataWidth-ToWidth){1'b0}}, to_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_PERIOD_RESET;
         to_ff   <= ACK_TIMEOUT_RESET;
      end else begin
         half_ff <= half_in;
         to_ff   <= to_in;
      end
   end

   assign cfg.half_period_ticks = half_ff;
   assign cfg.ack_timeout_ticks = to_ff;

endmodule

[hdl/i2cbm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_core
// Bus sequencer: advances one small step per accepted tick.
// ----------------------------------------------------------------------------
module i2cbm_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  i2cbm_pkg::req_type item,
   input  i2cbm_pkg::cfg_type cfg,
   output i2cbm_pkg::rsp_type res
);
   import i2cbm_pkg::*;

   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_ST1    = 4'd1;
   localparam logic [3:0] PH_ST2    = 4'd2;
   localparam logic [3:0] PH_SP1    = 4'd3;
   localparam logic [3:0] PH_SP2    = 4'd4;
   localparam logic [3:0] PH_GA1    = 4'd5;
   localparam logic [3:0] PH_GAPOLL = 4'd6;
   localparam logic [3:0] PH_SA1    = 4'd7;
   localparam logic [3:0] PH_SA2    = 4'd8;
   localparam logic [3:0] PH_WRLOW  = 4'd9;
   localparam logic [3:0] PH_WRHIGH = 4'd10;
   localparam logic [3:0] PH_RDLOW  = 4'd11;
   localparam logic [3:0] PH_RDHIGH = 4'd12;

   localparam logic [3:0] BitsPerByte = 4'd8;

   logic [3:0]           phase_ff, phase_in;
   logic [HalfWidth-1:0] delay_ff, delay_in;
   logic [3:0]           bit_ff, bit_in;
   logic [ByteWidth-1:0] shift_ff, shift_in;
   logic [ToWidth-1:0]   poll_ff, poll_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in_lvl;
   logic                 rel_ff, rel_in;
   logic [ByteWidth-1:0] rx_ff, rx_in;
   logic                 fail_ff, fail_in;
   logic                 done;
   logic                 do_poll;
   logic [HalfWidth-1:0] hold_val;
   logic [ToWidth-1:0]   poll_inc;

   // zero half period counts as one tick
   assign hold_val = (cfg.half_period_ticks == '0) ? {{(HalfWidth-1){1'b0}}, 1'b1}
                                                   : cfg.half_period_ticks;
   assign poll_inc = (poll_ff == {ToWidth{1'b1}}) ? poll_ff : poll_ff + 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      delay_in   = delay_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      poll_in    = poll_ff;
      scl_in     = scl_ff;
      sda_in_lvl = sda_ff;
      rel_in     = rel_ff;
      rx_in      = rx_ff;
      fail_in    = fail_ff;
      done       = 1'b0;
      do_poll    = 1'b0;

      if (phase_ff == PH_IDLE) begin
         case (item.cmd)
            CMD_START: begin
               rel_in = 1'b0; sda_in_lvl = 1'b1; scl_in = 1'b1;
               phase_in = PH_ST1; delay_in = hold_val;
            end
            CMD_STOP: begin
               rel_in = 1'b0; sda_in_lvl = 1'b0; scl_in = 1'b1;
               phase_in = PH_SP1; delay_in = hold_val;
            end
            CMD_WRITE: begin
               rel_in = 1'b0; scl_in = 1'b0;
               shift_in = item.tx_byte; bit_in = '0;
               phase_in = PH_WRLOW; delay_in = hold_val;
            end
            CMD_READ: begin
               rel_in = 1'b1; sda_in_lvl = 1'b1; scl_in = 1'b0;
               shift_in = '0; bit_in = '0;
               phase_in = PH_RDLOW; delay_in = hold_val;
            end
            CMD_SEND_ACK: begin
               rel_in = 1'b0; scl_in = 1'b0; sda_in_lvl = item.ack_bit;
               phase_in = PH_SA1; delay_in = hold_val;
            end
            CMD_GET_ACK: begin
               rel_in = 1'b1; sda_in_lvl = 1'b1; scl_in = 1'b0;
               poll_in = '0;
               phase_in = PH_GA1; delay_in = hold_val;
            end
            default: phase_in = PH_IDLE;
         endcase
      end else if (phase_ff == PH_GAPOLL) begin
         do_poll = 1'b1;
      end else if (delay_ff > {{(HalfWidth-1){1'b0}}, 1'b1}) begin
         delay_in = delay_ff - 1'b1;
      end else begin
         delay_in = '0;
         unique case (phase_ff)
            PH_ST1: begin
               sda_in_lvl = 1'b0; phase_in = PH_ST2; delay_in = hold_val;
            end
            PH_ST2: begin
               scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
            end
            PH_SP1: begin
               sda_in_lvl = 1'b1; phase_in = PH_SP2; delay_in = hold_val;
            end
            PH_SP2: begin
               phase_in = PH_IDLE; done = 1'b1;
            end
            PH_GA1: begin
               scl_in = 1'b1; phase_in = PH_GAPOLL; do_poll = 1'b1;
            end
            PH_SA1: begin
               scl_in = 1'b1; phase_in = PH_SA2; delay_in = hold_val;
            end
            PH_SA2: begin
               scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
            end
            PH_WRLOW: begin
               if (bit_ff >= BitsPerByte) begin
                  phase_in = PH_IDLE; done = 1'b1;
               end else begin
                  sda_in_lvl = shift_ff[ByteWidth-1];
                  shift_in   = {shift_ff[ByteWidth-2:0], 1'b0};
                  bit_in     = bit_ff + 1'b1;
                  scl_in     = 1'b1;
                  phase_in   = PH_WRHIGH; delay_in = hold_val;
               end
            end
            PH_WRHIGH: begin
               scl_in = 1'b0; phase_in = PH_WRLOW; delay_in = hold_val;
            end
            PH_RDLOW: begin
               scl_in   = 1'b1;
               shift_in = {shift_ff[ByteWidth-2:0], item.sda_in};
               bit_in   = bit_ff + 1'b1;
               phase_in = PH_RDHIGH; delay_in = hold_val;
            end
            PH_RDHIGH: begin
               scl_in = 1'b0;
               if (bit_ff >= BitsPerByte) begin
                  rx_in = shift_ff; phase_in = PH_IDLE; done = 1'b1;
               end else begin
                  phase_in = PH_RDLOW; delay_in = hold_val;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      // ack poll: low SDA ends the command, too many high polls force a stop
      if (do_poll) begin
         if (!item.sda_in) begin
            scl_in = 1'b0; fail_in = 1'b0;
            phase_in = PH_IDLE; delay_in = '0; done = 1'b1;
         end else begin
            poll_in = poll_inc;
            if (poll_inc >= cfg.ack_timeout_ticks) begin
               fail_in = 1'b1;
               rel_in = 1'b0; sda_in_lvl = 1'b0; scl_in = 1'b1;
               phase_in = PH_SP1; delay_in = hold_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         delay_ff <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         poll_ff  <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         rel_ff   <= 1'b0;
         rx_ff    <= '0;
         fail_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         poll_ff  <= poll_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_lvl;
         rel_ff   <= rel_in;
         rx_ff    <= rx_in;
         fail_ff  <= fail_in;
      end
   end

   // result shows the state after this tick
   assign res.scl_out        = scl_in;
   assign res.sda_out        = sda_in_lvl;
   assign res.sda_input_mode = rel_in;
   assign res.busy_res       = (phase_in != PH_IDLE);
   assign res.done_res       = done;
   assign res.rx_byte        = rx_in;
   assign res.ack_fail       = fail_in;

endmodule

[hdl/i2c_bit_level_master_top.sv]
`timescale 1ns / 1ps
// Result: a tick beat's result is registered and shows in the cycle after the beat is accepted.
// Throughput: one tick per cycle; the bus sequencer takes one step per beat,
// and a new beat is taken whenever the result register is empty or its beat
// leaves in the same cycle.
// Reset (synchronous, active high): bus idle with SCL and SDA high, registers
// back to half period 2 and ack timeout 250, result register empty.
// ----------------------------------------------------------------------------
// i2c_bit_level_master_top
// Bit-level I2C master with APB configuration and one result per tick.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_top (
   input  logic                            clock,
   input  logic                            reset,
   i2cbm_req_if.sink                       req_bus,
   i2cbm_rsp_if.source                     rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [i2cbm_pkg::AddrWidth-1:0] paddr,
   input  logic [i2cbm_pkg::DataWidth-1:0] pwdata,
   output logic [i2cbm_pkg::DataWidth-1:0] prdata,
   output logic                            pready
);
   import i2cbm_pkg::*;

   cfg_type cfg;
   req_type item;
   rsp_type res;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    accept;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign item.cmd     = req_bus.cmd;
   assign item.tx_byte = req_bus.tx_byte;
   assign item.ack_bit = req_bus.ack_bit;
   assign item.sda_in  = req_bus.sda_in;

   i2cbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   i2cbm_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .item  (item),
      .cfg   (cfg),
      .res   (res)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= res;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.scl_out        = rsp_ff.scl_out;
   assign rsp_bus.sda_out        = rsp_ff.sda_out;
   assign rsp_bus.sda_input_mode = rsp_ff.sda_input_mode;
   assign rsp_bus.busy_res       = rsp_ff.busy_res;
   assign rsp_bus.done_res       = rsp_ff.done_res;
   assign rsp_bus.rx_byte        = rsp_ff.rx_byte;
   assign rsp_bus.ack_fail       = rsp_ff.ack_fail;

endmodule

[hdl/i2cbm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_checker
// Port-level checks on the I2C master, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_bit_level_master_top_macros.svh"

module i2cbm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic sda_out,
   input logic sda_input_mode,
   input logic busy_res,
   input logic done_res
);

   // a held result is not dropped
   `I2CBM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped while stalled")

   // every accepted tick yields a result beat next cycle
   `I2CBM_ASSERT_NEXT(a_tick_result, clock, reset, req_valid && req_ready, rsp_valid, "accepted tick produced no result")

   // completion tick is never busy
   `I2CBM_ASSERT_SAME(a_done_idle, clock, reset, rsp_valid && done_res, !busy_res, "done with busy set")

   // released SDA reads as pull-up
   `I2CBM_ASSERT_SAME(a_release_high, clock, reset, rsp_valid && sda_input_mode, sda_out, "SDA released but not high")

endmodule

bind i2c_bit_level_master_top i2cbm_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .sda_out        (rsp_bus.sda_out),
   .sda_input_mode (rsp_bus.sda_input_mode),
   .busy_res       (rsp_bus.busy_res),
   .done_res       (rsp_bus.done_res)
);
